/* rtl/esf_pkg.sv */
// Shared types and constants for the XML element span finder.
// No dependencies; every other file in rtl/ imports this package.
package esf_pkg;

    localparam int unsigned MAX_TAG_CHARS_DEF = 16;
    localparam int unsigned TAG_BITS          = 128;
    localparam int unsigned TAG_LEN_W         = 5;
    localparam int unsigned OFFSET_W          = 32;
    localparam int unsigned APB_ADDR_W        = 5;
    localparam int unsigned APB_DATA_W        = 64;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_EOD  = 2'd1;
    localparam logic [1:0] KIND_NEW  = 2'd2;

    // Characters the scanner looks for
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Register indexes (byte address is 8 * index)
    typedef enum logic [1:0] {
        REG_TAG_LOW,
        REG_TAG_HIGH,
        REG_TAG_LEN
    } esf_reg_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]  chars;
        logic [TAG_LEN_W-1:0] length;
    } esf_tag_cfg_t;

    typedef struct packed {
        logic                valid;
        logic                found;
        logic                start_seen;
        logic [OFFSET_W-1:0] start_offset;
        logic [OFFSET_W-1:0] end_offset;
    } esf_result_t;

    // Character i of the tag name, character 0 in the lowest byte
    function automatic logic [7:0] tag_char(input logic [TAG_BITS-1:0] chars,
                                            input logic [3:0] idx);
        tag_char = chars[{idx, 3'b000} +: 8];
    endfunction

endpackage

/* rtl/esf_cfg_regs.sv */
// APB register file holding the tag name and its length.
// Depends on esf_pkg.
module esf_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [esf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [esf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [esf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output esf_pkg::esf_tag_cfg_t          tag_cfg
);
    import esf_pkg::*;

    logic [63:0]          tag_low_reg;
    logic [63:0]          tag_high_reg;
    logic [TAG_LEN_W-1:0] tag_len_reg;
    esf_reg_t             reg_sel;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_sel = esf_reg_t'(paddr[APB_ADDR_W-1:3]);
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_low_reg  <= '0;
            tag_high_reg <= '0;
            tag_len_reg  <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_TAG_LOW:  tag_low_reg  <= pwdata;
                REG_TAG_HIGH: tag_high_reg <= pwdata;
                REG_TAG_LEN:  tag_len_reg  <= pwdata[TAG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TAG_LOW:  prdata = tag_low_reg;
            REG_TAG_HIGH: prdata = tag_high_reg;
            REG_TAG_LEN:  prdata = APB_DATA_W'(tag_len_reg);
            default:      prdata = '0;
        endcase
    end

    assign tag_cfg.chars  = {tag_high_reg, tag_low_reg};
    assign tag_cfg.length = tag_len_reg;

endmodule

/* rtl/esf_scan.sv */
// Scan state machine: tag matching, offsets and result formation for one item.
// Depends on esf_pkg.
module esf_scan #(
    parameter int unsigned MAX_TAG_CHARS = esf_pkg::MAX_TAG_CHARS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         item_valid,
    input  logic                         advance,
    input  logic [1:0]                   kind,
    input  logic [7:0]                   data_byte,
    input  logic [esf_pkg::OFFSET_W-1:0] byte_offset,
    input  esf_pkg::esf_tag_cfg_t        tag_cfg,
    output esf_pkg::esf_result_t         result
);
    import esf_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_TAG_CHARS + 1);
    localparam logic [TAG_LEN_W-1:0] LEN_MAX = TAG_LEN_W'(MAX_TAG_CHARS);

    typedef enum logic [2:0] {
        WAIT_OPEN,
        START_NAME,
        WAIT_CLOSE,
        WAIT_SLASH,
        END_NAME
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [IDX_W-1:0]    match_idx_reg, match_idx_next;
    logic [OFFSET_W-1:0] cand_start_reg, cand_start_next;
    logic [OFFSET_W-1:0] saved_start_reg, saved_start_next;
    logic                start_rec_reg, start_rec_next;
    logic                done_reg, done_next;

    logic [IDX_W-1:0]    name_len;
    logic                name_done;
    logic                char_hit;

    assign name_len  = (tag_cfg.length > LEN_MAX) ? IDX_W'(MAX_TAG_CHARS)
                                                  : IDX_W'(tag_cfg.length);
    assign name_done = (match_idx_reg >= name_len);
    assign char_hit  = (data_byte == tag_char(tag_cfg.chars, 4'(match_idx_reg)));

    always_comb begin
        phase_next       = phase_reg;
        match_idx_next   = match_idx_reg;
        cand_start_next  = cand_start_reg;
        saved_start_next = saved_start_reg;
        start_rec_next   = start_rec_reg;
        done_next        = done_reg;
        result           = '0;

        if (item_valid) begin
            if (kind == KIND_NEW) begin
                phase_next       = WAIT_OPEN;
                match_idx_next   = '0;
                cand_start_next  = '0;
                saved_start_next = '0;
                start_rec_next   = 1'b0;
                done_next        = 1'b0;
            end else if (kind == KIND_EOD && !done_reg) begin
                result.valid        = 1'b1;
                result.start_seen   = start_rec_reg;
                result.start_offset = start_rec_reg ? saved_start_reg : '0;
                done_next           = 1'b1;
            end else if (kind == KIND_DATA && !done_reg) begin
                unique case (phase_reg)
                    WAIT_OPEN: begin
                        if (data_byte == CH_LT) begin
                            cand_start_next = byte_offset;
                            match_idx_next  = '0;
                            phase_next      = START_NAME;
                        end
                    end
                    START_NAME: begin
                        if (name_done) begin
                            if (data_byte == CH_SPACE || data_byte == CH_GT) begin
                                saved_start_next = cand_start_reg;
                                start_rec_next   = 1'b1;
                                phase_next       = WAIT_CLOSE;
                            end else begin
                                phase_next = WAIT_OPEN;
                            end
                        end else if (char_hit) begin
                            match_idx_next = match_idx_reg + 1'b1;
                        end else begin
                            phase_next = WAIT_OPEN;
                        end
                    end
                    WAIT_CLOSE: begin
                        if (data_byte == CH_LT)
                            phase_next = WAIT_SLASH;
                    end
                    WAIT_SLASH: begin
                        if (data_byte == CH_SLASH) begin
                            match_idx_next = '0;
                            phase_next     = END_NAME;
                        end else begin
                            phase_next = WAIT_CLOSE;
                        end
                    end
                    END_NAME: begin
                        if (name_done) begin
                            if (data_byte == CH_GT) begin
                                result.valid        = 1'b1;
                                result.found        = 1'b1;
                                result.start_seen   = 1'b1;
                                result.start_offset = saved_start_reg;
                                result.end_offset   = OFFSET_W'(byte_offset + 1'b1);
                                done_next           = 1'b1;
                            end else begin
                                phase_next = WAIT_CLOSE;
                            end
                        end else if (char_hit) begin
                            match_idx_next = match_idx_reg + 1'b1;
                        end else begin
                            phase_next = WAIT_CLOSE;
                        end
                    end
                    default: phase_next = WAIT_OPEN;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= WAIT_OPEN;
            match_idx_reg   <= '0;
            cand_start_reg  <= '0;
            saved_start_reg <= '0;
            start_rec_reg   <= 1'b0;
            done_reg        <= 1'b0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            match_idx_reg   <= match_idx_next;
            cand_start_reg  <= cand_start_next;
            saved_start_reg <= saved_start_next;
            start_rec_reg   <= start_rec_next;
            done_reg        <= done_next;
        end
    end

endmodule

/* rtl/xml_element_span_finder_unit.sv */
// Top level of the XML element span finder: input register, scanner, result register.
// Depends on esf_pkg, esf_cfg_regs and esf_scan.
//
// Usage:
//   The s_ channel carries one beat per stream event: a data byte with its offset,
//   an end-of-data marker, or a begin-new-search marker. The m_ channel carries at
//   most one result beat per input beat: found with the start offset of the opening
//   '<' and the offset just past the closing '>', or not found on end of data.
//   The tag name and its length are written over the APB port at byte addresses
//   0, 8 and 16; write them only while no beats are in flight.
// Timing:
//   An accepted beat is held in the input register and evaluated by the scanner;
//   its result enters the output register, which drives m_valid, when the scanner
//   advances. One beat per cycle is sustained while m_ready stays high; the scanner
//   state is a single register set updated by one compare-and-select step per byte.
// Reset:
//   aresetn (synchronous, active low) empties both registers, returns the scanner
//   to waiting for '<', and clears the tag registers.
// Stall:
//   While a result waits on m_ready, the input register holds its beat and s_ready
//   drops; once m_ready returns, both stages advance in the same cycle.
module xml_element_span_finder_unit #(
    parameter int unsigned MAX_TAG_CHARS = esf_pkg::MAX_TAG_CHARS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_kind,
    input  logic [7:0]                     s_data_byte,
    input  logic [esf_pkg::OFFSET_W-1:0]   s_byte_offset,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_found,
    output logic                           m_start_seen,
    output logic [esf_pkg::OFFSET_W-1:0]   m_start_offset,
    output logic [esf_pkg::OFFSET_W-1:0]   m_end_offset,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [esf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [esf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [esf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import esf_pkg::*;

    // Input register
    logic                in_valid_reg;
    logic [1:0]          in_kind_reg;
    logic [7:0]          in_byte_reg;
    logic [OFFSET_W-1:0] in_offset_reg;

    // Result register
    logic                out_valid_reg;
    logic                out_found_reg;
    logic                out_seen_reg;
    logic [OFFSET_W-1:0] out_start_reg;
    logic [OFFSET_W-1:0] out_end_reg;

    esf_tag_cfg_t tag_cfg;
    esf_result_t  result;
    logic         advance;

    // Move the held beat through the scanner when the result slot is free or draining
    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    // Take a new beat when the input register is empty or emptying this cycle
    assign s_ready = ~in_valid_reg | advance;

    esf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tag_cfg (tag_cfg)
    );

    esf_scan #(
        .MAX_TAG_CHARS (MAX_TAG_CHARS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (in_valid_reg),
        .advance     (advance),
        .kind        (in_kind_reg),
        .data_byte   (in_byte_reg),
        .byte_offset (in_offset_reg),
        .tag_cfg     (tag_cfg),
        .result      (result)
    );

    // Input stage: load on accept, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_kind_reg   <= s_kind;
            in_byte_reg   <= s_data_byte;
            in_offset_reg <= s_byte_offset;
        end
    end

    // Result stage: load when the scanner advances, drop once the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_found_reg <= result.found;
            out_seen_reg  <= result.start_seen;
            out_start_reg <= result.start_offset;
            out_end_reg   <= result.end_offset;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_found        = out_found_reg;
    assign m_start_seen   = out_seen_reg;
    assign m_start_offset = out_start_reg;
    assign m_end_offset   = out_end_reg;

`ifndef SYNTH
    a_found_has_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_start_seen)
        else $error("found result without a recognized start tag");

    a_miss_no_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_end_offset == '0)
        else $error("not-found result carries a nonzero end offset");

    a_miss_no_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_start_seen |-> m_start_offset == '0)
        else $error("start offset reported without a recognized start tag");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_offset_reg))
        else $error("held beat lost while the result stage was blocked");
`endif

endmodule
